// File: design/gmwt_pkg.sv
// Shared types, codes and constants of the G-code motion word tracker.
package gmwt_pkg;

   // Word letter codes on the request channel.
   localparam logic [2:0] FUNC_G = 3'd0;
   localparam logic [2:0] FUNC_X = 3'd1;
   localparam logic [2:0] FUNC_Y = 3'd2;
   localparam logic [2:0] FUNC_Z = 3'd3;
   localparam logic [2:0] FUNC_F = 3'd4;

   // G numbers that the tracker acts on.
   localparam logic [9:0] G_RAPID  = 10'd0;
   localparam logic [9:0] G_LINEAR = 10'd1;
   localparam logic [9:0] G_INCH   = 10'd20;
   localparam logic [9:0] G_MM     = 10'd21;
   localparam logic [9:0] G_ABS    = 10'd90;
   localparam logic [9:0] G_REL    = 10'd91;

   // Axis indexes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam int         NUM_AXES = 3;

   // Inch conversion: round(a * 25.4) = 25 * a + floor((2 * a + 2) / 5).
   localparam logic [32:0] INCH_WHOLE   = 33'd25;
   localparam logic [31:0] RECIP_FIVE   = 32'hCCCCCCCD;
   localparam int          RECIP_SHIFT  = 34;
   // Magnitudes at or above 2^27 always saturate after scaling.
   localparam int          INCH_MAG_BITS = 27;

   localparam logic [30:0] LIMIT_RESET = 31'd9830400;

   localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] POS_MIN = 32'sh80000000;
   localparam logic [32:0]        MAG_MAX = 33'h07FFFFFFF;
   localparam logic [32:0]        MAG_MIN = 33'h080000000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_MOVE,
      OP_ABS,
      OP_REL,
      OP_INCH,
      OP_MM,
      OP_AXIS,
      OP_FEED
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [1:0]         axis;
      logic               inch;
      logic signed [31:0] value;
      logic               line_end;
   } word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: design/gmwt_front.sv
// Front end: decodes each accepted word and tracks the unit mode.
module gmwt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [2:0]          req_func,
   input  logic [9:0]          req_g_number,
   input  logic signed [31:0]  req_word_value,
   input  logic                req_line_end,
   output gmwt_pkg::word_type  word
);

   logic            metric_ff;
   logic            metric_in;
   gmwt_pkg::op_type op;
   logic [1:0]      axis;

   always_comb begin
      op   = gmwt_pkg::OP_NONE;
      axis = gmwt_pkg::AXIS_X;
      case (req_func)
         gmwt_pkg::FUNC_G: begin
            case (req_g_number)
               gmwt_pkg::G_RAPID:  op = gmwt_pkg::OP_MOVE;
               gmwt_pkg::G_LINEAR: op = gmwt_pkg::OP_MOVE;
               gmwt_pkg::G_ABS:    op = gmwt_pkg::OP_ABS;
               gmwt_pkg::G_REL:    op = gmwt_pkg::OP_REL;
               gmwt_pkg::G_INCH:   op = gmwt_pkg::OP_INCH;
               gmwt_pkg::G_MM:     op = gmwt_pkg::OP_MM;
               default:            op = gmwt_pkg::OP_NONE;
            endcase
         end
         gmwt_pkg::FUNC_X: begin
            op   = gmwt_pkg::OP_AXIS;
            axis = gmwt_pkg::AXIS_X;
         end
         gmwt_pkg::FUNC_Y: begin
            op   = gmwt_pkg::OP_AXIS;
            axis = gmwt_pkg::AXIS_Y;
         end
         gmwt_pkg::FUNC_Z: begin
            op   = gmwt_pkg::OP_AXIS;
            axis = gmwt_pkg::AXIS_Z;
         end
         gmwt_pkg::FUNC_F: op = gmwt_pkg::OP_FEED;
         default:          op = gmwt_pkg::OP_NONE;
      endcase
   end

   // A unit change takes effect for the words after it.
   always_comb begin
      metric_in = metric_ff;
      if (accept && op == gmwt_pkg::OP_INCH) metric_in = 1'b0;
      if (accept && op == gmwt_pkg::OP_MM) metric_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= 1'b1;
      end else begin
         metric_ff <= metric_in;
      end
   end

   assign word.op       = op;
   assign word.axis     = axis;
   assign word.inch     = !metric_ff;
   assign word.value    = req_word_value;
   assign word.line_end = req_line_end;

endmodule

// File: design/gmwt_queue.sv
// Small FIFO of decoded words between the front end and the back end.
module gmwt_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  gmwt_pkg::word_type           push_word,
   input  logic                         pop,
   output gmwt_pkg::word_type           head,
   output gmwt_pkg::queue_status_type   status
);

   gmwt_pkg::word_type            mem_ff [gmwt_pkg::QUEUE_DEPTH];
   logic [gmwt_pkg::QUEUE_AW-1:0] wr_ptr_ff;
   logic [gmwt_pkg::QUEUE_AW-1:0] wr_ptr_in;
   logic [gmwt_pkg::QUEUE_AW-1:0] rd_ptr_ff;
   logic [gmwt_pkg::QUEUE_AW-1:0] rd_ptr_in;
   logic [gmwt_pkg::QUEUE_AW:0]   count_ff;
   logic [gmwt_pkg::QUEUE_AW:0]   count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (gmwt_pkg::QUEUE_AW + 1)'(gmwt_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// File: design/gmwt_back.sv
// Back end: unit conversion pipeline, modal position state and result register.
module gmwt_back (
   input  logic                        clock,
   input  logic                        reset,
   input  gmwt_pkg::word_type          head,
   input  gmwt_pkg::queue_status_type  status,
   output logic                        pop,
   input  logic                        csr_write_enable,
   input  logic [30:0]                 csr_write_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_new_x,
   output logic signed [31:0]          rsp_new_y,
   output logic signed [31:0]          rsp_new_z,
   output logic signed [31:0]          rsp_feed_out,
   output logic [2:0]                  rsp_over_limit_mask
);

   localparam int MB = gmwt_pkg::INCH_MAG_BITS;

   logic enable;

   // Stage 1: magnitude and the divide-by-five product.
   logic               s1_valid_ff;
   gmwt_pkg::word_type s1_word_ff;
   logic               s1_neg_ff;
   logic               s1_big_ff;
   logic [MB-1:0]      s1_mag_ff;
   logic [MB-1:0]      s1_fifth_ff;
   logic [31:0]        mag;
   logic [MB+1:0]      dividend;
   logic [63:0]        product;

   // Stage 2: converted value.
   logic               s2_valid_ff;
   gmwt_pkg::word_type s2_word_ff;
   logic signed [31:0] s2_value_ff;
   logic [32:0]        scaled;
   logic signed [31:0] converted;

   // Modal state.
   logic [30:0]        limit_ff;
   logic signed [31:0] cur_ff [gmwt_pkg::NUM_AXES];
   logic signed [31:0] cur_in [gmwt_pkg::NUM_AXES];
   logic signed [31:0] pend_ff [gmwt_pkg::NUM_AXES];
   logic signed [31:0] pend_in [gmwt_pkg::NUM_AXES];
   logic [2:0]         flags_ff;
   logic [2:0]         flags_in;
   logic [2:0]         flags_line;
   logic               move_ff;
   logic               move_in;
   logic               move_line;
   logic               abs_ff;
   logic               abs_in;
   logic signed [31:0] feed_ff;
   logic signed [31:0] feed_in;
   logic               emit;
   logic [2:0]         mask;
   logic signed [32:0] sum [gmwt_pkg::NUM_AXES];

   logic               out_valid_ff;
   logic signed [31:0] out_x_ff;
   logic signed [31:0] out_y_ff;
   logic signed [31:0] out_z_ff;
   logic signed [31:0] out_feed_ff;
   logic [2:0]         out_mask_ff;

   // The whole back end holds while a result waits at the output.
   assign enable = !out_valid_ff || rsp_ready;
   assign pop    = enable && !status.empty;

   always_comb begin
      mag      = head.value[31] ? (32'd0 - 32'(head.value)) : 32'(head.value);
      dividend = {1'b0, mag[MB-1:0], 1'b0} + (MB + 2)'(2);
      product  = 64'(dividend) * 64'(gmwt_pkg::RECIP_FIVE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_word_ff  <= head;
         s1_neg_ff   <= head.value[31];
         s1_big_ff   <= (mag[31:MB] != '0);
         s1_mag_ff   <= mag[MB-1:0];
         s1_fifth_ff <= product[gmwt_pkg::RECIP_SHIFT +: MB];
      end
   end

   always_comb begin
      scaled    = 33'(s1_mag_ff) * gmwt_pkg::INCH_WHOLE + 33'(s1_fifth_ff);
      converted = s1_word_ff.value;
      if (s1_word_ff.inch) begin
         if (s1_neg_ff) begin
            if (s1_big_ff || scaled > gmwt_pkg::MAG_MIN) begin
               converted = gmwt_pkg::POS_MIN;
            end else begin
               converted = 32'sd0 - $signed(scaled[31:0]);
            end
         end else begin
            if (s1_big_ff || scaled > gmwt_pkg::MAG_MAX) begin
               converted = gmwt_pkg::POS_MAX;
            end else begin
               converted = $signed(scaled[31:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_word_ff  <= s1_word_ff;
         s2_value_ff <= converted;
      end
   end

   // Stage 3: apply the word, then close the line when it is the last one.
   always_comb begin
      abs_in    = abs_ff;
      feed_in   = feed_ff;
      move_line = move_ff;
      flags_line = flags_ff;
      case (s2_word_ff.op)
         gmwt_pkg::OP_MOVE: move_line = 1'b1;
         gmwt_pkg::OP_ABS:  abs_in = 1'b1;
         gmwt_pkg::OP_REL:  abs_in = 1'b0;
         gmwt_pkg::OP_FEED: feed_in = s2_value_ff;
         gmwt_pkg::OP_AXIS: flags_line = flags_ff | (3'b001 << s2_word_ff.axis);
         default: ;
      endcase
      for (int i = 0; i < gmwt_pkg::NUM_AXES; i++) begin
         pend_in[i] = pend_ff[i];
         if (s2_word_ff.op == gmwt_pkg::OP_AXIS && s2_word_ff.axis == 2'(i)) begin
            pend_in[i] = s2_value_ff;
         end
      end
      emit = s2_word_ff.line_end && (move_line || flags_line != 3'b000);
      for (int i = 0; i < gmwt_pkg::NUM_AXES; i++) begin
         sum[i]    = 33'(cur_ff[i]) + 33'(pend_in[i]);
         cur_in[i] = cur_ff[i];
         if (flags_line[i]) begin
            if (abs_in) begin
               cur_in[i] = pend_in[i];
            end else if (sum[i][32] != sum[i][31]) begin
               cur_in[i] = sum[i][32] ? gmwt_pkg::POS_MIN : gmwt_pkg::POS_MAX;
            end else begin
               cur_in[i] = sum[i][31:0];
            end
         end
         mask[i] = !cur_in[i][31] && (cur_in[i][30:0] > limit_ff);
      end
      if (s2_word_ff.line_end) begin
         flags_in = 3'b000;
         move_in  = 1'b0;
      end else begin
         flags_in = flags_line;
         move_in  = move_line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= gmwt_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gmwt_pkg::NUM_AXES; i++) begin
            cur_ff[i] <= 32'sd0;
         end
         flags_ff     <= 3'b000;
         move_ff      <= 1'b0;
         abs_ff       <= 1'b1;
         feed_ff      <= 32'sd0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= s2_valid_ff && emit;
         if (s2_valid_ff) begin
            flags_ff <= flags_in;
            move_ff  <= move_in;
            abs_ff   <= abs_in;
            feed_ff  <= feed_in;
            if (emit) begin
               for (int i = 0; i < gmwt_pkg::NUM_AXES; i++) begin
                  cur_ff[i] <= cur_in[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable && s2_valid_ff) begin
         for (int i = 0; i < gmwt_pkg::NUM_AXES; i++) begin
            pend_ff[i] <= pend_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable && s2_valid_ff && emit) begin
         out_x_ff    <= cur_in[0];
         out_y_ff    <= cur_in[1];
         out_z_ff    <= cur_in[2];
         out_feed_ff <= feed_in;
         out_mask_ff <= mask;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_new_x           = out_x_ff;
   assign rsp_new_y           = out_y_ff;
   assign rsp_new_z           = out_z_ff;
   assign rsp_feed_out        = out_feed_ff;
   assign rsp_over_limit_mask = out_mask_ff;

endmodule

// File: design/gcode_motion_word_tracker_core.sv
// Top level of the G-code motion word tracker: front end, word queue and back end.
//
// Usage: the request channel carries one parsed G-code word per transaction
// (letter code, G number, signed Q16.16 value, end-of-line mark). The
// response channel carries one transaction for each line that held G0/G1 or
// an X, Y or Z word: the new position, the current feed and a mask of axes
// strictly above the travel limit. Other lines give no response.
// The csr port writes the 31-bit travel limit; write only while idle.
// Throughput: one word per cycle while req_ready is high. The word that
// closes a line passes the word queue, then the constant multiply of the
// inch conversion, then the saturating conversion, with the position
// update feeding the output register that holds the response.
// When the receiver stalls, the back end holds and the 4-entry queue keeps
// taking words until it fills; req_ready then drops.
// Synchronous reset restores millimetre units, absolute mode, zero position
// and feed, the 150 mm limit, and empties the queue and the output.
module gcode_motion_word_tracker_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic [9:0]         req_g_number,
   input  logic signed [31:0] req_word_value,
   input  logic               req_line_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_new_x,
   output logic signed [31:0] rsp_new_y,
   output logic signed [31:0] rsp_new_z,
   output logic signed [31:0] rsp_feed_out,
   output logic [2:0]         rsp_over_limit_mask,
   input  logic               csr_write_enable,
   input  logic [30:0]        csr_write_data
);

   logic                       accept;
   logic                       pop;
   gmwt_pkg::word_type         front_word;
   gmwt_pkg::word_type         head_word;
   gmwt_pkg::queue_status_type q_status;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   gmwt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_func       (req_func),
      .req_g_number   (req_g_number),
      .req_word_value (req_word_value),
      .req_line_end   (req_line_end),
      .word           (front_word)
   );

   gmwt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_word (front_word),
      .pop       (pop),
      .head      (head_word),
      .status    (q_status)
   );

   gmwt_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head_word),
      .status              (q_status),
      .pop                 (pop),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_new_x           (rsp_new_x),
      .rsp_new_y           (rsp_new_y),
      .rsp_new_z           (rsp_new_z),
      .rsp_feed_out        (rsp_feed_out),
      .rsp_over_limit_mask (rsp_over_limit_mask)
   );

   // The queue and the output register are empty right after reset.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (q_status.empty && !q_status.full && !rsp_valid))
      else $error("queue or response not cleared by reset");

   // An axis above a nonnegative limit can never be negative.
   a_mask_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_over_limit_mask[0] && rsp_new_x[31]) &&
                    !(rsp_over_limit_mask[1] && rsp_new_y[31]) &&
                    !(rsp_over_limit_mask[2] && rsp_new_z[31]))
      else $error("over-limit flag set on a negative position");

   // Nothing leaves an empty queue.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("pop from an empty word queue");

   // A held response keeps the back end, and so the queue head, in place.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !pop)
      else $error("back end advanced while a response was stalled");

endmodule

// File: verif/tb.sv
// Self-checking testbench for the G-code motion word tracker: directed table, then random lines.
module tb;

   localparam logic [2:0] FUNC_OTHER = 3'd5;
   localparam int RANDOM_WORDS = 650;
   localparam int PHASES = 5;

   typedef struct {
      logic [2:0]         func;
      logic [9:0]         g_number;
      logic signed [31:0] value;
      logic               line_end;
   } gword_type;

   typedef struct {
      logic signed [31:0] x, y, z, feed;
      logic [2:0]         mask;
   } move_result_type;

   typedef struct {
      gword_type       w;
      bit              typed;
      move_result_type r;
   } plan_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_func = '0;
   logic [9:0]         req_g_number = '0;
   logic signed [31:0] req_word_value = '0;
   logic               req_line_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_new_x, rsp_new_y, rsp_new_z, rsp_feed_out;
   logic [2:0]         rsp_over_limit_mask;
   logic               csr_write_enable = 1'b0;
   logic [30:0]        csr_write_data = '0;

   // Shadow copy of the tracker state.
   logic signed [31:0] pos_now [3];
   logic signed [31:0] held_axis [3];
   logic signed [31:0] feed_now;
   logic [2:0]         held_flags;
   bit                 abs_mode, mm_units, move_pending;
   logic [30:0]        travel_limit;

   move_result_type expected_moves [$];
   plan_row_type    directed [$];
   bit              steady = 1'b0;
   int              errors = 0;
   int              words_sent = 0;
   int              ready_hold = 0;

   gcode_motion_word_tracker_core DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_g_number        (req_g_number),
      .req_word_value      (req_word_value),
      .req_line_end        (req_line_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_new_x           (rsp_new_x),
      .rsp_new_y           (rsp_new_y),
      .rsp_new_z           (rsp_new_z),
      .rsp_feed_out        (rsp_feed_out),
      .rsp_over_limit_mask (rsp_over_limit_mask),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #4 clock = ~clock;

   initial begin
      #3200000;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
   endtask

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > longint'(gmwt_pkg::POS_MAX)) return gmwt_pkg::POS_MAX;
      if (v < longint'(gmwt_pkg::POS_MIN)) return gmwt_pkg::POS_MIN;
      return v[31:0];
   endfunction

   // Inch values are scaled by 25.4, rounded to nearest, away from zero on a tie.
   function automatic logic signed [31:0] to_mm(input logic signed [31:0] v);
      longint scaled, mag, q;
      if (mm_units) return v;
      scaled = longint'(v) * 254;
      mag = scaled < 0 ? -scaled : scaled;
      q = (mag + 5) / 10;
      return clamp32(scaled < 0 ? -q : q);
   endfunction

   task automatic track_word(input gword_type w, output bit closes,
                             output move_result_type r);
      logic signed [31:0] nxt;
      int a;
      closes = 1'b0;
      case (w.func)
         gmwt_pkg::FUNC_G: begin
            if (w.g_number == gmwt_pkg::G_RAPID || w.g_number == gmwt_pkg::G_LINEAR)
               move_pending = 1'b1;
            else if (w.g_number == gmwt_pkg::G_ABS) abs_mode = 1'b1;
            else if (w.g_number == gmwt_pkg::G_REL) abs_mode = 1'b0;
            else if (w.g_number == gmwt_pkg::G_INCH) mm_units = 1'b0;
            else if (w.g_number == gmwt_pkg::G_MM) mm_units = 1'b1;
         end
         gmwt_pkg::FUNC_X, gmwt_pkg::FUNC_Y, gmwt_pkg::FUNC_Z: begin
            a = int'(w.func) - 1;
            held_axis[a] = to_mm(w.value);
            held_flags[a] = 1'b1;
         end
         gmwt_pkg::FUNC_F: feed_now = to_mm(w.value);
         default: ;
      endcase
      if (!w.line_end) return;
      if (!move_pending && held_flags == 3'b000) return;
      r.mask = 3'b000;
      for (a = 0; a < 3; a++) begin
         nxt = pos_now[a];
         if (held_flags[a]) begin
            if (abs_mode) nxt = held_axis[a];
            else nxt = clamp32(longint'(pos_now[a]) + longint'(held_axis[a]));
         end
         if (longint'(nxt) > longint'(travel_limit)) r.mask[a] = 1'b1;
         pos_now[a] = nxt;
      end
      held_flags = 3'b000;
      move_pending = 1'b0;
      r.x = pos_now[0];
      r.y = pos_now[1];
      r.z = pos_now[2];
      r.feed = feed_now;
      closes = 1'b1;
   endtask

   function automatic int idle_len();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [9:0] pick_code(input bit modes_only);
      case ($urandom_range(modes_only ? 2 : 0, 5))
         0: return gmwt_pkg::G_RAPID;
         1: return gmwt_pkg::G_LINEAR;
         2: return gmwt_pkg::G_ABS;
         3: return gmwt_pkg::G_REL;
         4: return gmwt_pkg::G_INCH;
         default: return gmwt_pkg::G_MM;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return gmwt_pkg::POS_MAX;
         1: return gmwt_pkg::POS_MIN;
         2, 3: return $urandom;
         // Around the magnitude where inch scaling starts to saturate.
         4: return $urandom_range(0, 32'h0C000000) - 32'h06000000;
         default: return $urandom_range(0, 26214400) - 13107200;
      endcase
   endfunction

   function automatic void add_row(input logic [2:0] f, input logic [9:0] g,
                                   input logic signed [31:0] v, input logic e,
                                   input bit typed = 1'b0,
                                   input logic signed [31:0] x = 0, y = 0, z = 0, feed = 0,
                                   input logic [2:0] mask = 3'b000);
      plan_row_type row;
      row.w.func = f;
      row.w.g_number = g;
      row.w.value = v;
      row.w.line_end = e;
      row.typed = typed;
      row.r.x = x;
      row.r.y = y;
      row.r.z = z;
      row.r.feed = feed;
      row.r.mask = mask;
      directed.push_back(row);
   endfunction

   // Valid is only dropped when a gap follows, so it is never lowered and raised in one step.
   task automatic send_word(input gword_type w, input bit typed, input move_result_type want);
      int gap;
      bit closes;
      move_result_type got;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= w.func;
      req_g_number <= w.g_number;
      req_word_value <= w.value;
      req_line_end <= w.line_end;
      do @(posedge clock); while (!req_ready);
      track_word(w, closes, got);
      if (closes) expected_moves.push_back(typed ? want : got);
      words_sent++;
   endtask

   // The limit is only written once the tracker has drained and gone quiet.
   task automatic set_limit(input logic [30:0] lim);
      req_valid <= 1'b0;
      while (expected_moves.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= lim;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      travel_limit = lim;
   endtask

   always @(posedge clock) begin
      if (ready_hold != 0) ready_hold--;
      else begin
         ready_hold = idle_len();
         rsp_ready <= (ready_hold == 0);
         if (ready_hold == 0) ready_hold = $urandom_range(0, 6);
      end
   end

   always @(posedge clock) begin
      move_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_moves.size() == 0) report_mismatch("response with no line waiting");
         else begin
            want = expected_moves.pop_front();
            if (rsp_new_x !== want.x)
               report_mismatch($sformatf("new_x %h, expected %h", rsp_new_x, want.x));
            if (rsp_new_y !== want.y)
               report_mismatch($sformatf("new_y %h, expected %h", rsp_new_y, want.y));
            if (rsp_new_z !== want.z)
               report_mismatch($sformatf("new_z %h, expected %h", rsp_new_z, want.z));
            if (rsp_feed_out !== want.feed)
               report_mismatch($sformatf("feed_out %h, expected %h", rsp_feed_out, want.feed));
            if (rsp_over_limit_mask !== want.mask)
               report_mismatch($sformatf("over_limit_mask %b, expected %b",
                                         rsp_over_limit_mask, want.mask));
         end
      end
   end

   initial begin
      gword_type       w;
      gword_type       line_words [$];
      move_result_type none;
      int              phase, k, n, waited;
      logic [30:0]     lim;

      for (k = 0; k < 3; k++) begin
         pos_now[k] = '0;
         held_axis[k] = '0;
      end
      feed_now = '0;
      held_flags = 3'b000;
      abs_mode = 1'b1;
      mm_units = 1'b1;
      move_pending = 1'b0;
      travel_limit = gmwt_pkg::LIMIT_RESET;

      // Absolute millimetre moves against the 150 mm limit left by reset.
      add_row(gmwt_pkg::FUNC_G, gmwt_pkg::G_LINEAR, 0, 1'b0);
      add_row(gmwt_pkg::FUNC_X, 0, 655360, 1'b1, 1'b1, 655360, 0, 0, 0, 3'b000);
      add_row(gmwt_pkg::FUNC_F, 0, 6553600, 1'b1);
      add_row(gmwt_pkg::FUNC_Y, 0, gmwt_pkg::POS_MAX, 1'b1, 1'b1,
              655360, gmwt_pkg::POS_MAX, 0, 6553600, 3'b010);
      add_row(gmwt_pkg::FUNC_Z, 0, gmwt_pkg::POS_MIN, 1'b1, 1'b1,
              655360, gmwt_pkg::POS_MAX, gmwt_pkg::POS_MIN, 6553600, 3'b010);
      add_row(gmwt_pkg::FUNC_X, 0, 9830400, 1'b1, 1'b1,
              9830400, gmwt_pkg::POS_MAX, gmwt_pkg::POS_MIN, 6553600, 3'b010);
      add_row(gmwt_pkg::FUNC_X, 0, 9830401, 1'b1, 1'b1,
              9830401, gmwt_pkg::POS_MAX, gmwt_pkg::POS_MIN, 6553600, 3'b011);
      // Relative moves that saturate in both directions.
      add_row(gmwt_pkg::FUNC_G, gmwt_pkg::G_REL, 0, 1'b0);
      add_row(gmwt_pkg::FUNC_X, 0, gmwt_pkg::POS_MAX, 1'b0);
      add_row(gmwt_pkg::FUNC_Y, 0, 1, 1'b1);
      add_row(gmwt_pkg::FUNC_Z, 0, gmwt_pkg::POS_MIN, 1'b1);
      // Inch words, with absolute mode restored mid-line and an ignored letter closing it.
      add_row(gmwt_pkg::FUNC_G, gmwt_pkg::G_INCH, 0, 1'b0);
      add_row(gmwt_pkg::FUNC_X, 0, gmwt_pkg::POS_MAX, 1'b0);
      add_row(gmwt_pkg::FUNC_G, gmwt_pkg::G_ABS, 0, 1'b0);
      add_row(gmwt_pkg::FUNC_Y, 0, gmwt_pkg::POS_MIN, 1'b0);
      add_row(gmwt_pkg::FUNC_Z, 0, 1, 1'b0);
      add_row(gmwt_pkg::FUNC_F, 0, -3, 1'b0);
      add_row(FUNC_OTHER, 0, gmwt_pkg::POS_MAX, 1'b1);
      add_row(gmwt_pkg::FUNC_X, 0, 32'h08000000, 1'b1);
      add_row(gmwt_pkg::FUNC_G, gmwt_pkg::G_MM, 0, 1'b0);
      add_row(gmwt_pkg::FUNC_G, gmwt_pkg::G_RAPID, 0, 1'b1);
      // Lines that must give nothing.
      add_row(gmwt_pkg::FUNC_G, 10'd999, 0, 1'b1);
      add_row(3'd7, 0, gmwt_pkg::POS_MAX, 1'b1);
      add_row(3'd6, 10'd24, 0, 1'b1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_word(directed[i].w, directed[i].typed, directed[i].r);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: lim = '0;
            1: lim = 31'h7FFFFFFF;
            2: lim = $urandom_range(0, 20000000);
            3: lim = $urandom_range(0, 32'h7FFFFFFF);
            default: lim = $urandom_range(0, 20000000);
         endcase
         set_limit(lim);
         steady = (phase == 2);
         while (words_sent < directed.size() + (phase + 1) * (RANDOM_WORDS / PHASES)) begin
            line_words.delete();
            if ($urandom_range(0, 99) < 80) begin
               n = $urandom_range(0, 3);
               for (k = 0; k < n; k++) begin
                  w.func = gmwt_pkg::FUNC_X + $urandom_range(0, 2);
                  w.g_number = $urandom_range(0, 999);
                  w.value = pick_value();
                  w.line_end = 1'b0;
                  line_words.push_back(w);
               end
               if ($urandom_range(0, 9) < 3) begin
                  w.func = gmwt_pkg::FUNC_F;
                  w.value = pick_value();
                  line_words.push_back(w);
               end
               if ($urandom_range(0, 1)) begin
                  w.func = gmwt_pkg::FUNC_G;
                  w.g_number = $urandom_range(0, 1) ? gmwt_pkg::G_LINEAR : gmwt_pkg::G_RAPID;
                  line_words.insert($urandom_range(0, line_words.size()), w);
               end
               n = $urandom_range(0, 2);
               for (k = 0; k < n; k++) begin
                  w.func = gmwt_pkg::FUNC_G;
                  w.g_number = pick_code(1'b1);
                  w.value = $urandom;
                  // Mode words mostly lead the line, sometimes land between axis words.
                  if ($urandom_range(0, 9) < 6) line_words.push_front(w);
                  else line_words.insert($urandom_range(0, line_words.size()), w);
               end
               if (line_words.size() == 0) begin
                  w.func = FUNC_OTHER;
                  w.value = $urandom;
                  line_words.push_back(w);
               end
               line_words[line_words.size() - 1].line_end = 1'b1;
            end else begin
               n = $urandom_range(1, 4);
               for (k = 0; k < n; k++) begin
                  w.func = $urandom_range(0, 7);
                  w.g_number = $urandom_range(0, 1) ? pick_code(1'b0) : 10'($urandom_range(0, 999));
                  w.value = $urandom;
                  w.line_end = $urandom_range(0, 1);
                  line_words.push_back(w);
               end
            end
            foreach (line_words[i]) send_word(line_words[i], 1'b0, none);
         end
      end

      req_valid <= 1'b0;
      waited = 0;
      while (expected_moves.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (expected_moves.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_moves.size()));

      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
design/gmwt_pkg.sv
design/gmwt_front.sv
design/gmwt_queue.sv
design/gmwt_back.sv
design/gcode_motion_word_tracker_core.sv
verif/tb.sv
